>>> design/epsilon_greedy_arm_selector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the epsilon-greedy arm selector
// Concurrent assertion shorthands clocked on clk, optionally gated by rst.
// ----------------------------------------------------------------------------
`ifndef EPSILON_GREEDY_ARM_SELECTOR_MACROS_SVH
`define EPSILON_GREEDY_ARM_SELECTOR_MACROS_SVH

// checked outside reset only
`define EGAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define EGAS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/egas_pkg.sv
// ----------------------------------------------------------------------------
// egas_pkg
// Widths, stream layout and the per-arm statistics record.
// ----------------------------------------------------------------------------
package egas_pkg;

  localparam int unsigned DEF_NUM_ARMS = 10;

  localparam int unsigned ARM_W    = 4;
  localparam int unsigned REWARD_W = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned PROD_W   = SUM_W + CNT_W + 1;

  localparam int unsigned S_TDATA_W = 24;  // 1 + 4 + 16 = 21 bits, padded
  localparam int unsigned M_TDATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
  } stat_t;

endpackage

>>> design/egas_stats.sv
// ----------------------------------------------------------------------------
// egas_stats
// Per-arm count/sum memory: one write and one registered read port.
// Entries never written since reset read as zero via per-entry valid bits.
// ----------------------------------------------------------------------------
module egas_stats
  import egas_pkg::*;
#(
  parameter int unsigned NUM_ARMS = DEF_NUM_ARMS,
  parameter int unsigned IDX_W    = $clog2(NUM_ARMS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  stat_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output stat_t            rd_data
);

  stat_t               mem [NUM_ARMS];
  logic [NUM_ARMS-1:0] vld;
  stat_t               rd_raw;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

>>> design/egas_cmp.sv
// ----------------------------------------------------------------------------
// egas_cmp
// Shared mean compare: cand beats best when sum_c * cnt_b > sum_b * cnt_c.
// Products are registered; the decision comes in the cycle after en.
// ----------------------------------------------------------------------------
module egas_cmp
  import egas_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  stat_t cand,
  input  stat_t best,
  output logic  better,
  output stat_t cand_q
);

  logic signed [PROD_W-1:0] p_cand;
  logic signed [PROD_W-1:0] p_best;
  logic                     zero_c;
  logic                     zero_b;
  logic                     best_neg;
  logic                     cand_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      p_cand   <= cand.sum * $signed({1'b0, best.count});
      p_best   <= best.sum * $signed({1'b0, cand.count});
      zero_c   <= (cand.count == '0);
      zero_b   <= (best.count == '0);
      best_neg <= best.sum[SUM_W-1];
      cand_pos <= !cand.sum[SUM_W-1] && (cand.sum != '0);
      cand_q   <= cand;
    end
  end

  // an unplayed arm has mean zero
  always_comb begin
    if (zero_c && zero_b) begin
      better = 1'b0;
    end else if (zero_c) begin
      better = best_neg;
    end else if (zero_b) begin
      better = cand_pos;
    end else begin
      better = (p_cand > p_best);
    end
  end

endmodule

>>> design/epsilon_greedy_arm_selector.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector
// Each input beat reports one play: the played arm (the given random arm when
// explore is set, else the stored greedy arm) gets the Q4.12 reward added to
// its sum and its count bumped (both freeze once the count reaches 65535).
// All arms are then scanned from arm 0 with the played arm as the starting
// best; means are compared by cross-multiplication, an unplayed arm counting
// as mean 0, ties keeping the current best. One output beat carries the
// played arm and the winner, which also becomes the next greedy arm. An item
// occupies the block from accept to the next possible accept: a multiply and
// a compare state per arm through the shared multiply/compare unit, which
// reads one arm per step from the stats memory, plus the read-modify-write
// of the played arm. s_tready is low meanwhile; the output register lets a
// finished result wait while the next item runs.
// ----------------------------------------------------------------------------
module epsilon_greedy_arm_selector
  import egas_pkg::*;
#(
  parameter int unsigned NUM_ARMS = DEF_NUM_ARMS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // explore, random_arm[3:0], reward[15:0], pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // played_arm[3:0], next_arm[3:0]
);

  localparam int unsigned IDX_W = $clog2(NUM_ARMS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_ARMS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDP,
    S_UPD,
    S_RD0,
    S_MUL,
    S_CMP,
    S_DONE
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           played;
  logic signed [REWARD_W-1:0] reward_q;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           best_idx;
  stat_t                      best;
  logic [ARM_W-1:0]           greedy;
  logic [ARM_W-1:0]           out_played;
  logic [ARM_W-1:0]           out_next;

  logic                       explore;
  logic [ARM_W-1:0]           random_arm;
  logic signed [REWARD_W-1:0] reward;
  logic [ARM_W-1:0]           sel_arm;
  logic [IDX_W-1:0]           played_in;

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  stat_t                      rd_data;
  logic                       wr_en;
  stat_t                      upd_stat;
  logic                       better;
  stat_t                      cand_q;

  assign explore    = s_tdata[0];
  assign random_arm = s_tdata[4:1];
  assign reward     = $signed(s_tdata[20:5]);

  assign sel_arm   = explore ? random_arm : greedy;
  assign played_in = (int'(sel_arm) >= NUM_ARMS) ? LAST : IDX_W'(sel_arm);

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {out_next, out_played};

  // saturating update of the played arm
  always_comb begin
    upd_stat = rd_data;
    if (rd_data.count != CNT_MAX) begin
      upd_stat.count = rd_data.count + 1'b1;
      upd_stat.sum   = rd_data.sum + SUM_W'(reward_q);
    end
  end

  assign wr_en = (state == S_UPD);

  // reads run one arm ahead of the compare
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_RDP: begin
        rd_en   = 1'b1;
        rd_addr = played;
      end
      S_RD0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_MUL: begin
        rd_en   = (idx != LAST);
        rd_addr = idx + 1'b1;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  egas_stats #(
    .NUM_ARMS (NUM_ARMS),
    .IDX_W    (IDX_W)
  ) u_stats (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (played),
    .wr_data (upd_stat),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  egas_cmp u_cmp (
    .clk    (clk),
    .en     (state == S_MUL),
    .cand   (rd_data),
    .best   (best),
    .better (better),
    .cand_q (cand_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      greedy   <= '0;
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      // S_DONE reloads the output register itself
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            played   <= played_in;
            reward_q <= reward;
            state    <= S_RDP;
          end
        end
        S_RDP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          best     <= upd_stat;
          best_idx <= played;
          state    <= S_RD0;
        end
        S_RD0: begin
          idx   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (better) begin
            best     <= cand_q;
            best_idx <= idx;
          end
          if (idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_played <= ARM_W'(played);
            out_next   <= ARM_W'(best_idx);
            greedy     <= ARM_W'(best_idx);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/egas_checker.sv
// ----------------------------------------------------------------------------
// egas_checker
// Port-level checks for the arm selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "epsilon_greedy_arm_selector_macros.svh"

module egas_checker
  import egas_pkg::*;
#(
  parameter int unsigned NUM_ARMS = DEF_NUM_ARMS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result beat holds
  `EGAS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")

  // one item at a time: busy right after an accept
  `EGAS_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "accepted a beat while busy")

  // both reported arms are real arms
  `EGAS_ASSERT(a_arm_range, m_tvalid |-> (m_tdata[3:0] < NUM_ARMS) && (m_tdata[7:4] < NUM_ARMS), "arm index out of range")

  // no result straight out of reset
  `EGAS_ASSERT_ALWAYS(a_reset_clean, $past(rst) |-> !m_tvalid, "output valid right after reset")

endmodule

bind epsilon_greedy_arm_selector egas_checker #(.NUM_ARMS(NUM_ARMS)) u_egas_checker (.*);
